// ----- rtl/bds_pkg.sv -----
// Shared types and constants of the 2x2 box downsampler.
`default_nettype none

package bds_pkg;

  // Default maximum image size in pixels.
  localparam int MaxWidthDef  = 4096;
  localparam int MaxHeightDef = 4096;

  // Configuration port layout.
  localparam int CfgDataW   = 13;
  localparam int CfgIdxW    = 2;
  localparam int SizeReset  = 4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_FOUR_CHANNELS = 2'd2
  } cfg_idx_e;

  // Channel bytes and the horizontal pair sums of all four channels.
  localparam int ChanW  = 8;
  localparam int LanesN = 4;
  localparam int PairW  = ChanW + 1;
  localparam int SumsW  = LanesN * PairW;

  typedef struct packed {
    logic [ChanW-1:0] chan_a;
    logic [ChanW-1:0] chan_b;
    logic [ChanW-1:0] chan_g;
    logic [ChanW-1:0] chan_r;
  } pix_t;

  typedef struct packed {
    logic [ChanW-1:0] out_a;
    logic [ChanW-1:0] out_b;
    logic [ChanW-1:0] out_g;
    logic [ChanW-1:0] out_r;
    logic             frame_end;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/bds_pix_if.sv -----
// Source pixel channel: valid/ready handshake with one pixel per beat.
`default_nettype none

interface bds_pix_if;
  logic          valid;
  logic          ready;
  bds_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bds_res_if.sv -----
// Output pixel channel: valid/ready handshake with one averaged pixel per beat.
`default_nettype none

interface bds_res_if;
  logic          valid;
  logic          ready;
  bds_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/box_downsample_2x2.sv -----
// Top level of the 2x2 box-filter downsampler with its line store.
`default_nettype none

// The block takes source pixels in raster order, one beat per pixel, and
// emits an image half as wide and half as high. Each output channel is the
// sum of a 2x2 block of source pixels shifted right by two. On even rows
// the sum of each horizontal pixel pair goes into a line store (one entry
// per output column, four 9-bit sums); on odd rows the stored sum is read
// back and added to the current pair sum, giving one output beat per odd
// column. An odd last column or row is consumed and produces nothing.
// Sizes outside 2..MAX_WIDTH / 2..MAX_HEIGHT saturate to that range.
// With four_channels at zero, out_a is zero. frame_end marks the last
// output beat of an image. Throughput is one pixel per clock, held only by
// output backpressure: the line store is a single-port memory touched once
// per pixel pair (a write on even rows, a read on odd rows), and its
// registered read data meets the registered pair sum in stage 1 in the cycle
// after the odd-column pixel is taken; the result then passes through the
// output register. Every store entry is written on an even row at least one
// accepted pixel before the odd row reads it, so no forwarding is needed.
// Configuration must be written by the user only while no beat is in
// flight; the block does not enforce this. There is no clearing pass after reset.
module box_downsample_2x2 #(
  parameter int MAX_WIDTH  = bds_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bds_pkg::MaxHeightDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [bds_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [bds_pkg::CfgDataW-1:0]  cfg_data_i,
  bds_pix_if.sink                      pix_i,
  bds_res_if.source                    res_o
);

  localparam int ColW      = $clog2(MAX_WIDTH);
  localparam int RowW      = $clog2(MAX_HEIGHT);
  localparam int OxW       = ColW - 1;
  localparam int OyW       = RowW - 1;
  localparam int WCntW     = $clog2(MAX_WIDTH + 1);
  localparam int HCntW     = $clog2(MAX_HEIGHT + 1);
  localparam int LineDepth = MAX_WIDTH / 2;
  localparam int AddrW     = $clog2(LineDepth);
  localparam int CmpW      = 32;
  localparam int ResetW    = (bds_pkg::SizeReset > MAX_WIDTH) ? MAX_WIDTH
                                                              : bds_pkg::SizeReset;
  localparam int ResetH    = (bds_pkg::SizeReset > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : bds_pkg::SizeReset;
  localparam int ChanW     = bds_pkg::ChanW;
  localparam int PairW     = bds_pkg::PairW;
  localparam int SumsW     = bds_pkg::SumsW;
  localparam int LanesN    = bds_pkg::LanesN;

  // ---------------------------------------------------------------------
  // Configuration. The clamped sizes are turned into the last column, last
  // row and last output coordinates right at the write.
  // ---------------------------------------------------------------------
  logic [ColW-1:0] last_col_q;
  logic [RowW-1:0] last_row_q;
  logic [OxW-1:0]  last_ox_q;
  logic [OyW-1:0]  last_oy_q;
  logic            four_q;
  logic [WCntW-1:0] w_clamp;
  logic [HCntW-1:0] h_clamp;

  always_comb begin
    if (CmpW'(cfg_data_i) < CmpW'(2)) begin
      w_clamp = WCntW'(2);
    end else if (CmpW'(cfg_data_i) > CmpW'(MAX_WIDTH)) begin
      w_clamp = WCntW'(MAX_WIDTH);
    end else begin
      w_clamp = WCntW'(cfg_data_i);
    end
    if (CmpW'(cfg_data_i) < CmpW'(2)) begin
      h_clamp = HCntW'(2);
    end else if (CmpW'(cfg_data_i) > CmpW'(MAX_HEIGHT)) begin
      h_clamp = HCntW'(MAX_HEIGHT);
    end else begin
      h_clamp = HCntW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= ColW'(ResetW - 1);
      last_ox_q  <= OxW'(ResetW / 2 - 1);
      last_row_q <= RowW'(ResetH - 1);
      last_oy_q  <= OyW'(ResetH / 2 - 1);
      four_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bds_pkg::CFG_SOURCE_WIDTH: begin
          last_col_q <= ColW'(w_clamp - WCntW'(1));
          last_ox_q  <= OxW'((w_clamp >> 1) - WCntW'(1));
        end
        bds_pkg::CFG_SOURCE_HEIGHT: begin
          last_row_q <= RowW'(h_clamp - HCntW'(1));
          last_oy_q  <= OyW'((h_clamp >> 1) - HCntW'(1));
        end
        bds_pkg::CFG_FOUR_CHANNELS: begin
          four_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: position counters, pending even-column pixel, pair sums and
  // the line store access.
  // ---------------------------------------------------------------------
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  bds_pkg::pix_t    pend_q;
  logic [SumsW-1:0] pair_sums;
  logic [OxW-1:0]   ox;
  logic [OyW-1:0]   oy;
  logic             pix_acc;
  logic             pair_in;
  logic             mem_we;
  logic             mem_re;
  logic             last_out;
  logic             s1_valid_q;
  logic             s1_go;
  logic             out_valid_q;

  assign s1_go       = s1_valid_q && (!out_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_go;
  assign pix_acc     = pix_i.valid && pix_i.ready;

  assign ox       = col_q[ColW-1:1];
  assign oy       = row_q[RowW-1:1];
  assign pair_in  = pix_acc && col_q[0] && (ox <= last_ox_q);
  assign mem_we   = pair_in && !row_q[0];
  assign mem_re   = pair_in && row_q[0] && (oy <= last_oy_q);
  assign last_out = (ox == last_ox_q) && (oy == last_oy_q);

  always_comb begin
    for (int k = 0; k < LanesN; k++) begin
      pair_sums[k*PairW +: PairW] = PairW'(pend_q[k*ChanW +: ChanW])
                                  + PairW'(pix_i.data[k*ChanW +: ChanW]);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_acc) begin
      if (col_q >= last_col_q) begin
        col_d = '0;
        row_d = (row_q >= last_row_q) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc && !col_q[0]) begin
      pend_q <= pix_i.data;
    end
  end

  // Line store: one port, registered read data held until the next read.
  logic [SumsW-1:0] line_mem [LineDepth];
  logic [SumsW-1:0] above_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[ox[AddrW-1:0]] <= pair_sums;
    end
    if (mem_re) begin
      above_q <= line_mem[ox[AddrW-1:0]];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: the current pair sums wait here for the stored row above.
  // ---------------------------------------------------------------------
  logic [SumsW-1:0] s1_sums_q;
  logic             s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (mem_re) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_sums_q <= pair_sums;
      s1_last_q <= last_out;
    end
  end

  // Vertical add and divide by four.
  bds_pkg::res_t res_d;
  logic [PairW:0] quad [LanesN];

  always_comb begin
    for (int k = 0; k < LanesN; k++) begin
      quad[k] = (PairW + 1)'(above_q[k*PairW +: PairW])
              + (PairW + 1)'(s1_sums_q[k*PairW +: PairW]);
    end
    res_d.out_r     = quad[0][PairW:2];
    res_d.out_g     = quad[1][PairW:2];
    res_d.out_b     = quad[2][PairW:2];
    res_d.out_a     = four_q ? quad[3][PairW:2] : '0;
    res_d.frame_end = s1_last_q;
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  bds_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_port_single_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("line store written and read in the same cycle");

  a_read_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> s1_valid_q)
    else $error("line store read did not load stage 1");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(s1_sums_q) && $stable(above_q)))
    else $error("stalled stage 1 lost its operands");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(res_q)))
    else $error("output register overwritten while stalled");

  a_alpha_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && !four_q) |=> (res_q.out_a == '0))
    else $error("alpha not zero in three channel mode");

endmodule

`default_nettype wire
